@@ rtl/wddm_pkg.sv @@
// ============================================================================
// wddm_pkg
// shared types and constants of the windowed direct dft magnitude block
// ============================================================================
package wddm_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int BIN_W       = 38;
    localparam int BIN_INDEX_W = 6;
    localparam int ACC_W       = 40;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_ENABLE    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAGNITUDE_ENABLE = 8'd1;

    localparam logic [BIN_W-1:0] BIN_MAG_MAX = {1'b0, {(BIN_W-1){1'b1}}};

    typedef struct packed {
        logic                   load_we;
        logic [BIN_INDEX_W-1:0] load_addr;
        logic                   snap;
        logic                   issue;
        logic                   first;
        logic                   last;
        logic [BIN_INDEX_W-1:0] j;
        logic [BIN_INDEX_W-1:0] ph;
        logic                   mag_start;
        logic                   out_load;
        logic [BIN_INDEX_W-1:0] k;
        logic                   last_bin;
    } wddm_cmd_t;

    typedef struct packed {
        logic acc_done;
        logic mag_done;
        logic mag_en;
    } wddm_status_t;

endpackage

@@ rtl/wddm_sqrt.sv @@
// ============================================================================
// wddm_sqrt
// serial sum of squares and digit by digit floor square root
// ============================================================================
module wddm_sqrt (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [wddm_pkg::ACC_W-1:0] re,
    input  logic signed [wddm_pkg::ACC_W-1:0] im,
    output logic                              done,
    output logic [wddm_pkg::BIN_W-1:0]        root
);
    import wddm_pkg::*;

    localparam int SQ_W  = 2 * ACC_W + 2;
    localparam int REM_W = ACC_W + 3;
    localparam int RT_W  = ACC_W + 1;

    localparam logic [1:0] SQ_IDLE = 2'd0;
    localparam logic [1:0] SQ_MUL  = 2'd1;
    localparam logic [1:0] SQ_ROOT = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [5:0]           cnt_reg, cnt_next;
    logic [2*ACC_W-1:0]   a_mc_reg, a_mc_next, b_mc_reg, b_mc_next;
    logic [ACC_W-1:0]     a_mp_reg, a_mp_next, b_mp_reg, b_mp_next;
    logic [SQ_W-1:0]      sq_reg, sq_next;
    logic [REM_W-1:0]     rem_reg, rem_next, rem_sh, trial;
    logic [RT_W-1:0]      root_reg, root_next;
    logic                 done_reg, done_next;
    logic [ACC_W-1:0]     abs_re, abs_im;

    assign abs_re = re[ACC_W-1] ? ACC_W'(-re) : ACC_W'(re);
    assign abs_im = im[ACC_W-1] ? ACC_W'(-im) : ACC_W'(im);
    assign rem_sh = {rem_reg[REM_W-3:0], sq_reg[SQ_W-1 -: 2]};
    assign trial  = {root_reg[REM_W-3:0], 2'b01};

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        a_mc_next  = a_mc_reg;
        b_mc_next  = b_mc_reg;
        a_mp_next  = a_mp_reg;
        b_mp_next  = b_mp_reg;
        sq_next    = sq_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            SQ_IDLE: begin
                if (start) begin
                    a_mc_next  = (2*ACC_W)'(abs_re);
                    b_mc_next  = (2*ACC_W)'(abs_im);
                    a_mp_next  = abs_re;
                    b_mp_next  = abs_im;
                    sq_next    = '0;
                    cnt_next   = '0;
                    state_next = SQ_MUL;
                end
            end
            SQ_MUL: begin
                sq_next = sq_reg
                        + (a_mp_reg[0] ? SQ_W'(a_mc_reg) : '0)
                        + (b_mp_reg[0] ? SQ_W'(b_mc_reg) : '0);
                a_mc_next = a_mc_reg << 1;
                b_mc_next = b_mc_reg << 1;
                a_mp_next = a_mp_reg >> 1;
                b_mp_next = b_mp_reg >> 1;
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == 6'(ACC_W - 1)) begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    root_next  = '0;
                    state_next = SQ_ROOT;
                end
            end
            SQ_ROOT: begin
                if (rem_sh >= trial) begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[RT_W-2:0], 1'b1};
                end else begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[RT_W-2:0], 1'b0};
                end
                sq_next  = {sq_reg[SQ_W-3:0], 2'b00};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(RT_W - 1)) begin
                    done_next  = 1'b1;
                    state_next = SQ_IDLE;
                end
            end
            default: state_next = SQ_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SQ_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
        a_mc_reg <= a_mc_next;
        b_mc_reg <= b_mc_next;
        a_mp_reg <= a_mp_next;
        b_mp_reg <= b_mp_next;
        sq_reg   <= sq_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = (root_reg > RT_W'(BIN_MAG_MAX)) ? BIN_MAG_MAX : root_reg[BIN_W-1:0];

endmodule

@@ rtl/wddm_datapath.sv @@
// ============================================================================
// wddm_datapath
// frame store, window and twiddle roms, mac pipeline and result register
// ============================================================================
module wddm_datapath #(
    parameter int POINTS = 64
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  wddm_pkg::wddm_cmd_t                    cmd,
    output wddm_pkg::wddm_status_t                 status,
    input  logic                                   window_enable,
    input  logic                                   magnitude_enable,
    input  logic signed [wddm_pkg::SAMPLE_W-1:0]   sample_re,
    input  logic signed [wddm_pkg::SAMPLE_W-1:0]   sample_im,
    output logic signed [wddm_pkg::BIN_W-1:0]      bin_re,
    output logic signed [wddm_pkg::BIN_W-1:0]      bin_im,
    output logic [wddm_pkg::BIN_INDEX_W-1:0]       bin_index,
    output logic                                   last_bin
);
    import wddm_pkg::*;

    localparam int IDX_W = $clog2(POINTS);
    localparam int W_W   = 17;

    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
    localparam longint          Q30_ONE     = 64'sd1073741824;
    localparam longint          WIN_A0      = 64'sd382002981;
    localparam longint          WIN_A1      = 64'sd523337470;
    localparam longint          WIN_A2      = 64'sd154868031;
    localparam longint          WIN_A3      = 64'sd13533442;

    function automatic longint rnd_shift(input longint v, input int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint q30_trig(input longint unsigned t, input bit want_sin);
        longint unsigned quad, r, x, x2, tc, ts;
        longint c, s, co, si;
        quad = (t >> 30) & 64'd3;
        r    = t & 64'h3FFF_FFFF;
        x    = (r * PI_HALF_Q30) >> 30;
        x2   = (x * x) >> 30;
        tc   = 64'd1073741824;
        ts   = x;
        c    = Q30_ONE;
        s    = longint'(x);
        tc = ((tc * x2) >> 30) / 64'd2;
        ts = ((ts * x2) >> 30) / 64'd6;
        c  = c - longint'(tc);
        s  = s - longint'(ts);
        tc = ((tc * x2) >> 30) / 64'd12;
        ts = ((ts * x2) >> 30) / 64'd20;
        c  = c + longint'(tc);
        s  = s + longint'(ts);
        tc = ((tc * x2) >> 30) / 64'd30;
        ts = ((ts * x2) >> 30) / 64'd42;
        c  = c - longint'(tc);
        s  = s - longint'(ts);
        tc = ((tc * x2) >> 30) / 64'd56;
        ts = ((ts * x2) >> 30) / 64'd72;
        c  = c + longint'(tc);
        s  = s + longint'(ts);
        tc = ((tc * x2) >> 30) / 64'd90;
        ts = ((ts * x2) >> 30) / 64'd110;
        c  = c - longint'(tc);
        s  = s - longint'(ts);
        tc = ((tc * x2) >> 30) / 64'd132;
        ts = ((ts * x2) >> 30) / 64'd156;
        c  = c + longint'(tc);
        s  = s + longint'(ts);
        tc = ((tc * x2) >> 30) / 64'd182;
        ts = ((ts * x2) >> 30) / 64'd210;
        c  = c - longint'(tc);
        s  = s - longint'(ts);
        tc = ((tc * x2) >> 30) / 64'd240;
        ts = ((ts * x2) >> 30) / 64'd272;
        c  = c + longint'(tc);
        s  = s + longint'(ts);
        if (c < 0) c = 0;
        if (c > Q30_ONE) c = Q30_ONE;
        if (s < 0) s = 0;
        if (s > Q30_ONE) s = Q30_ONE;
        unique case (quad)
            64'd0:   begin co = c;  si = s;  end
            64'd1:   begin co = -s; si = c;  end
            64'd2:   begin co = -c; si = -s; end
            default: begin co = s;  si = -c; end
        endcase
        return want_sin ? si : co;
    endfunction

    function automatic longint q15_sat(input longint v);
        longint r;
        r = rnd_shift(v, 15);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r;
    endfunction

    function automatic longint unsigned phase_n(input longint unsigned p);
        return ((p % POINTS) << 32) / POINTS;
    endfunction

    function automatic longint unsigned phase_nm1(input longint unsigned p);
        return ((p % (POINTS - 1)) << 32) / (POINTS - 1);
    endfunction

    function automatic longint win_weight(input int i);
        longint w;
        w = WIN_A0;
        w = w - rnd_shift(WIN_A1 * q30_trig(phase_nm1(longint'(i)), 1'b0), 30);
        w = w + rnd_shift(WIN_A2 * q30_trig(phase_nm1(longint'(2 * i)), 1'b0), 30);
        w = w - rnd_shift(WIN_A3 * q30_trig(phase_nm1(longint'(3 * i)), 1'b0), 30);
        w = rnd_shift(w, 15);
        if (w < 0) w = 0;
        if (w > 32767) w = 32767;
        return w;
    endfunction

    function automatic logic [POINTS*SAMPLE_W-1:0] build_tw(input bit want_sin);
        logic [POINTS*SAMPLE_W-1:0] t;
        t = '0;
        for (int m = 0; m < POINTS; m++) begin
            t[m*SAMPLE_W +: SAMPLE_W] =
                SAMPLE_W'(q15_sat(q30_trig(phase_n(longint'(m)), want_sin)));
        end
        return t;
    endfunction

    function automatic logic [POINTS*W_W-1:0] build_win();
        logic [POINTS*W_W-1:0] t;
        t = '0;
        for (int i = 0; i < POINTS; i++) begin
            if (i < POINTS / 2) begin
                t[i*W_W +: W_W] = W_W'(win_weight(i));
            end else if (POINTS - 1 - i < POINTS / 2) begin
                t[i*W_W +: W_W] = W_W'(win_weight(POINTS - 1 - i));
            end else begin
                t[i*W_W +: W_W] = W_W'(32768);
            end
        end
        return t;
    endfunction

    localparam logic [POINTS*SAMPLE_W-1:0] COS_TAB = build_tw(1'b0);
    localparam logic [POINTS*SAMPLE_W-1:0] SIN_TAB = build_tw(1'b1);
    localparam logic [POINTS*W_W-1:0]      WIN_TAB = build_win();

    logic [2*SAMPLE_W-1:0] mem [POINTS];

    logic                         win_en_reg, mag_en_reg;
    logic [2*SAMPLE_W-1:0]        rd_reg;
    logic signed [SAMPLE_W-1:0]   cos1_reg, sin1_reg, cos2_reg, sin2_reg;
    logic [W_W-1:0]               w_reg;
    logic                         v1_reg, first1_reg, last1_reg;
    logic signed [SAMPLE_W:0]     xr_reg;
    logic signed [SAMPLE_W-1:0]   xi_reg;
    logic                         v2_reg, first2_reg, last2_reg;
    logic signed [2*SAMPLE_W:0]   p_rc_reg, p_is_reg, p_ic_reg, p_rs_reg;
    logic                         v3_reg, first3_reg, last3_reg;
    logic signed [ACC_W-1:0]      acc_re_reg, acc_im_reg, sum_re, sum_im;
    logic                         done_reg;
    logic signed [BIN_W-1:0]      bin_re_reg, bin_im_reg;
    logic [BIN_INDEX_W-1:0]       bin_index_reg;
    logic                         last_bin_reg;
    logic signed [2*SAMPLE_W+2:0] wprod;
    logic signed [2*SAMPLE_W+2:0] wrnd;
    logic                         mag_done;
    logic [BIN_W-1:0]             mag_root;

    always_ff @(posedge aclk) begin
        if (cmd.load_we) begin
            mem[cmd.load_addr[IDX_W-1:0]] <= {sample_im, sample_re};
        end
        if (cmd.issue) begin
            rd_reg <= mem[cmd.j[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_en_reg <= 1'b0;
            mag_en_reg <= 1'b0;
        end else if (cmd.snap) begin
            win_en_reg <= window_enable;
            mag_en_reg <= magnitude_enable;
        end
    end

    assign wprod = $signed(rd_reg[SAMPLE_W-1:0]) * $signed({1'b0, w_reg});
    assign wrnd  = (wprod + (2*SAMPLE_W+3)'(16384)) >>> 15;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            v1_reg   <= cmd.issue;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg && last3_reg;
        end
        first1_reg <= cmd.first;
        last1_reg  <= cmd.last;
        cos1_reg   <= $signed(COS_TAB[cmd.ph[IDX_W-1:0]*SAMPLE_W +: SAMPLE_W]);
        sin1_reg   <= $signed(SIN_TAB[cmd.ph[IDX_W-1:0]*SAMPLE_W +: SAMPLE_W]);
        w_reg      <= win_en_reg ? WIN_TAB[cmd.j[IDX_W-1:0]*W_W +: W_W] : W_W'(32768);

        first2_reg <= first1_reg;
        last2_reg  <= last1_reg;
        cos2_reg   <= cos1_reg;
        sin2_reg   <= sin1_reg;
        xr_reg     <= wrnd[SAMPLE_W:0];
        xi_reg     <= $signed(rd_reg[2*SAMPLE_W-1:SAMPLE_W]);

        first3_reg <= first2_reg;
        last3_reg  <= last2_reg;
        p_rc_reg   <= xr_reg * cos2_reg;
        p_is_reg   <= xi_reg * sin2_reg;
        p_ic_reg   <= xi_reg * cos2_reg;
        p_rs_reg   <= xr_reg * sin2_reg;

        if (v3_reg) begin
            acc_re_reg <= (first3_reg ? '0 : acc_re_reg) + sum_re;
            acc_im_reg <= (first3_reg ? '0 : acc_im_reg) + sum_im;
        end
    end

    assign sum_re = ACC_W'(p_rc_reg) + ACC_W'(p_is_reg);
    assign sum_im = ACC_W'(p_ic_reg) - ACC_W'(p_rs_reg);

    wddm_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mag_start),
        .re      (acc_re_reg),
        .im      (acc_im_reg),
        .done    (mag_done),
        .root    (mag_root)
    );

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            bin_re_reg    <= mag_en_reg ? $signed(mag_root) : acc_re_reg[BIN_W-1:0];
            bin_im_reg    <= acc_im_reg[BIN_W-1:0];
            bin_index_reg <= cmd.k;
            last_bin_reg  <= cmd.last_bin;
        end
    end

    assign status.acc_done = done_reg;
    assign status.mag_done = mag_done;
    assign status.mag_en   = mag_en_reg;

    assign bin_re    = bin_re_reg;
    assign bin_im    = bin_im_reg;
    assign bin_index = bin_index_reg;
    assign last_bin  = last_bin_reg;

endmodule

@@ rtl/wddm_ctrl.sv @@
// ============================================================================
// wddm_ctrl
// frame load, bin and sample sequencing, result handshake
// ============================================================================
module wddm_ctrl #(
    parameter int POINTS = 64
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  logic                    m_ready,
    output wddm_pkg::wddm_cmd_t     cmd,
    input  wddm_pkg::wddm_status_t  status
);
    import wddm_pkg::*;

    localparam int IDX_W = $clog2(POINTS);

    localparam logic [2:0] ST_LOAD     = 3'd0;
    localparam logic [2:0] ST_RUN      = 3'd1;
    localparam logic [2:0] ST_WAIT_ACC = 3'd2;
    localparam logic [2:0] ST_WAIT_MAG = 3'd3;
    localparam logic [2:0] ST_OUT      = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] load_reg, load_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] ph_reg, ph_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [IDX_W:0]   ph_sum;
    logic             j_last, k_last, load_last;

    assign j_last    = (j_reg == IDX_W'(POINTS - 1));
    assign k_last    = (k_reg == IDX_W'(POINTS - 1));
    assign load_last = (load_reg == IDX_W'(POINTS - 1));
    assign ph_sum    = {1'b0, ph_reg} + {1'b0, k_reg};

    always_comb begin
        state_next = state_reg;
        load_next  = load_reg;
        j_next     = j_reg;
        ph_next    = ph_reg;
        k_next     = k_reg;

        cmd           = '0;
        cmd.load_addr = BIN_INDEX_W'(load_reg);
        cmd.j         = BIN_INDEX_W'(j_reg);
        cmd.ph        = BIN_INDEX_W'(ph_reg);
        cmd.k         = BIN_INDEX_W'(k_reg);
        cmd.first     = (j_reg == '0);
        cmd.last      = j_last;
        cmd.last_bin  = k_last;

        unique case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    cmd.load_we = 1'b1;
                    load_next   = load_reg + 1'b1;
                    if (load_last) begin
                        cmd.snap   = 1'b1;
                        load_next  = '0;
                        j_next     = '0;
                        ph_next    = '0;
                        k_next     = '0;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                cmd.issue = 1'b1;
                j_next    = j_reg + 1'b1;
                ph_next   = (ph_sum >= (IDX_W+1)'(POINTS)) ?
                            IDX_W'(ph_sum - (IDX_W+1)'(POINTS)) : IDX_W'(ph_sum);
                if (j_last) begin
                    j_next     = '0;
                    state_next = ST_WAIT_ACC;
                end
            end
            ST_WAIT_ACC: begin
                if (status.acc_done) begin
                    if (status.mag_en) begin
                        cmd.mag_start = 1'b1;
                        state_next    = ST_WAIT_MAG;
                    end else begin
                        cmd.out_load = 1'b1;
                        state_next   = ST_OUT;
                    end
                end
            end
            ST_WAIT_MAG: begin
                if (status.mag_done) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    ph_next = '0;
                    if (k_last) begin
                        k_next     = '0;
                        state_next = ST_LOAD;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_RUN;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            load_reg  <= '0;
            j_reg     <= '0;
            ph_reg    <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            load_reg  <= load_next;
            j_reg     <= j_next;
            ph_reg    <= ph_next;
            k_reg     <= k_next;
        end
    end

    assign s_ready = (state_reg == ST_LOAD);
    assign m_valid = (state_reg == ST_OUT);

endmodule

@@ rtl/windowed_direct_dft_magnitude_top.sv @@
// ============================================================================
// windowed_direct_dft_magnitude_top
// windowed direct dft over a frame of POINTS samples, optional bin magnitude
// ============================================================================
//  channel  prefix  transfer
//  input    s_      one complex q1.15 sample
//  result   m_      one bin: re or magnitude, im, index, last flag
//  config   cfg_    register index and write data
//
//  a frame loads at one sample per cycle while s_valid is high; then each bin
//  streams all POINTS samples through the single multiply-accumulate pipeline,
//  and magnitude mode adds a pass through the serial square root unit
//  input is not taken while bins are produced; a stalled result holds the
//  block until it is taken. synchronous active-low reset, no clearing pass
// ============================================================================
module windowed_direct_dft_magnitude_top #(
    parameter int POINTS = 64
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [wddm_pkg::SAMPLE_W-1:0]   s_sample_re,
    input  logic signed [wddm_pkg::SAMPLE_W-1:0]   s_sample_im,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [wddm_pkg::BIN_W-1:0]      m_bin_re,
    output logic signed [wddm_pkg::BIN_W-1:0]      m_bin_im,
    output logic [wddm_pkg::BIN_INDEX_W-1:0]       m_bin_index,
    output logic                                   m_last_bin,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [wddm_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [wddm_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
    import wddm_pkg::*;

    logic         window_enable_reg, magnitude_enable_reg;
    wddm_cmd_t    cmd;
    wddm_status_t status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_enable_reg    <= 1'b0;
            magnitude_enable_reg <= 1'b0;
        end else if (cfg_valid) begin
            if (cfg_index == REG_WINDOW_ENABLE) begin
                window_enable_reg <= cfg_wdata[0];
            end
            if (cfg_index == REG_MAGNITUDE_ENABLE) begin
                magnitude_enable_reg <= cfg_wdata[0];
            end
        end
    end

    wddm_ctrl #(
        .POINTS (POINTS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    wddm_datapath #(
        .POINTS (POINTS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .window_enable    (window_enable_reg),
        .magnitude_enable (magnitude_enable_reg),
        .sample_re        (s_sample_re),
        .sample_im        (s_sample_im),
        .bin_re           (m_bin_re),
        .bin_im           (m_bin_im),
        .bin_index        (m_bin_index),
        .last_bin         (m_last_bin)
    );

endmodule

@@ tb/wddm_checker.sv @@
// ============================================================================
// wddm_checker
// watches the sample, bin and register channels of the windowed dft block,
// predicts every bin of each loaded frame and compares bins field by field
// ============================================================================
module wddm_checker #(
    parameter int POINTS = 64
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    input  logic                                   s_ready,
    input  logic signed [wddm_pkg::SAMPLE_W-1:0]   s_sample_re,
    input  logic signed [wddm_pkg::SAMPLE_W-1:0]   s_sample_im,
    input  logic                                   m_valid,
    input  logic                                   m_ready,
    input  logic [wddm_pkg::BIN_W-1:0]             m_bin_re,
    input  logic [wddm_pkg::BIN_W-1:0]             m_bin_im,
    input  logic [wddm_pkg::BIN_INDEX_W-1:0]       m_bin_index,
    input  logic                                   m_last_bin,
    input  logic                                   cfg_valid,
    input  logic                                   cfg_ready,
    input  logic [wddm_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [wddm_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    output int                                     fail_count,
    output int                                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import wddm_pkg::*;

    localparam longint PI_HALF_Q30 = 64'd1686629713;
    localparam longint COEF_A0     = 64'd382002981;
    localparam longint COEF_A1     = 64'd523337470;
    localparam longint COEF_A2     = 64'd154868031;
    localparam longint COEF_A3     = 64'd13533442;
    localparam longint ONE_Q30     = 64'd1073741824;

    typedef struct {
        logic [BIN_W-1:0]       re;
        logic [BIN_W-1:0]       im;
        logic [BIN_INDEX_W-1:0] idx;
        logic                   last;
    } bin_t;

    bin_t            bins_due[$];
    longint          twid_cos[POINTS];
    longint          twid_sin[POINTS];
    longint          win_weight[POINTS];
    logic [15:0]     frame_re[POINTS];
    logic [15:0]     frame_im[POINTS];
    int              load_count;
    logic            window_on;
    logic            magnitude_on;

    function automatic longint round_shift(input longint x, input int sh);
        return (x + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic [31:0] turn_phase(input longint unsigned p,
                                               input longint unsigned q);
        longint unsigned m;
        m = p % q;
        return 32'((m << 32) / q);
    endfunction

    function automatic void cos_sin_q30(input logic [31:0] t, output longint co,
                                        output longint si);
        longint unsigned r, x, x2, tc, ts;
        longint c, s;
        r  = longint'(t[29:0]);
        x  = (r * PI_HALF_Q30) >> 30;
        x2 = (x * x) >> 30;
        tc = ONE_Q30;
        ts = x;
        c  = ONE_Q30;
        s  = x;
        for (int n = 1; n <= 8; n++) begin
            tc = ((tc * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
            ts = ((ts * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                c -= tc;
                s -= ts;
            end else begin
                c += tc;
                s += ts;
            end
        end
        if (c < 0) c = 0;
        if (c > ONE_Q30) c = ONE_Q30;
        if (s < 0) s = 0;
        if (s > ONE_Q30) s = ONE_Q30;
        case (t[31:30])
            2'd0: begin co = c;  si = s;  end
            2'd1: begin co = -s; si = c;  end
            2'd2: begin co = -c; si = -s; end
            default: begin co = s; si = -c; end
        endcase
    endfunction

    function automatic longint to_q15(input longint v);
        longint r;
        r = round_shift(v, 15);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r;
    endfunction

    function automatic longint nuttall_weight(input int i);
        longint c, s, w;
        w = COEF_A0;
        cos_sin_q30(turn_phase(i, POINTS - 1), c, s);
        w -= round_shift(COEF_A1 * c, 30);
        cos_sin_q30(turn_phase(2 * i, POINTS - 1), c, s);
        w += round_shift(COEF_A2 * c, 30);
        cos_sin_q30(turn_phase(3 * i, POINTS - 1), c, s);
        w -= round_shift(COEF_A3 * c, 30);
        w = round_shift(w, 15);
        if (w < 0) w = 0;
        if (w > 32767) w = 32767;
        return w;
    endfunction

    function automatic logic [BIN_W-1:0] bin_magnitude(input longint re, input longint im);
        logic [79:0] ar, ai, sq, c;
        logic [79:0] r;
        ar = re < 0 ? -re : re;
        ai = im < 0 ? -im : im;
        sq = ar * ar + ai * ai;
        r  = '0;
        for (int b = 38; b >= 0; b--) begin
            c = r | (80'd1 << b);
            if (c * c <= sq) r = c;
        end
        if (r > 80'(BIN_MAG_MAX)) r = 80'(BIN_MAG_MAX);
        return r[BIN_W-1:0];
    endfunction

    initial begin
        longint c, s;
        for (int p = 0; p < POINTS; p++) begin
            cos_sin_q30(turn_phase(p, POINTS), c, s);
            twid_cos[p] = to_q15(c);
            twid_sin[p] = to_q15(s);
        end
        for (int i = 0; i < POINTS; i++) win_weight[i] = 32768;
        for (int i = 0; i < POINTS / 2; i++) begin
            win_weight[i]              = nuttall_weight(i);
            win_weight[POINTS - 1 - i] = win_weight[i];
        end
    end

    // full frame loaded: queue every bin of its transform
    function automatic void predict_frame_bins();
        longint xr[POINTS], xi[POINTS];
        longint sr, si, c, s;
        bin_t b;
        for (int i = 0; i < POINTS; i++) begin
            xr[i] = longint'($signed(frame_re[i]));
            xi[i] = longint'($signed(frame_im[i]));
            if (window_on && win_weight[i] != 32768)
                xr[i] = round_shift(xr[i] * win_weight[i], 15);
        end
        for (int k = 0; k < POINTS; k++) begin
            sr = 0;
            si = 0;
            for (int j = 0; j < POINTS; j++) begin
                c = twid_cos[(k * j) % POINTS];
                s = twid_sin[(k * j) % POINTS];
                sr += xr[j] * c + xi[j] * s;
                si += xi[j] * c - xr[j] * s;
            end
            b.re   = magnitude_on ? bin_magnitude(sr, si) : sr[BIN_W-1:0];
            b.im   = si[BIN_W-1:0];
            b.idx  = k[BIN_INDEX_W-1:0];
            b.last = (k == POINTS - 1);
            bins_due.push_back(b);
        end
    endfunction

    always @(posedge aclk) begin
        bin_t e;
        int errs;
        errs = 0;
        if (!aresetn) begin
            load_count   = 0;
            window_on    = 1'b0;
            magnitude_on = 1'b0;
            bins_due.delete();
            fail_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_WINDOW_ENABLE) window_on = cfg_wdata[0];
                else if (cfg_index == REG_MAGNITUDE_ENABLE) magnitude_on = cfg_wdata[0];
            end
            if (m_valid && m_ready) begin
                if (bins_due.size() == 0) begin
                    $error("bin transfer with nothing expected, index %0d", m_bin_index);
                    errs++;
                end else begin
                    e = bins_due.pop_front();
                    if (m_bin_re !== e.re) begin
                        $error("bin_re expected %0h actual %0h", e.re, m_bin_re);
                        errs++;
                    end
                    if (m_bin_im !== e.im) begin
                        $error("bin_im expected %0h actual %0h", e.im, m_bin_im);
                        errs++;
                    end
                    if (m_bin_index !== e.idx) begin
                        $error("bin_index expected %0d actual %0d", e.idx, m_bin_index);
                        errs++;
                    end
                    if (m_last_bin !== e.last) begin
                        $error("last_bin expected %0b actual %0b", e.last, m_last_bin);
                        errs++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                frame_re[load_count] = s_sample_re;
                frame_im[load_count] = s_sample_im;
                load_count++;
                if (load_count == POINTS) begin
                    load_count = 0;
                    predict_frame_bins();
                end
            end
            fail_count <= fail_count + errs;
        end
        pending <= bins_due.size();
    end

endmodule

@@ tb/tb_windowed_direct_dft_magnitude_top.sv @@
// ============================================================================
// tb_windowed_direct_dft_magnitude_top
// drives frames of samples and register writes into the windowed dft block
// under random idling and a long result stall; a checker predicts all bins
// ============================================================================
module tb_windowed_direct_dft_magnitude_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wddm_pkg::*;

    localparam int POINTS      = 64;
    localparam int CYCLE_LIMIT = 1000000;

    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 8'd5;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic signed [SAMPLE_W-1:0]    s_sample_re;
    logic signed [SAMPLE_W-1:0]    s_sample_im;
    logic                          m_valid;
    logic                          m_ready;
    logic signed [BIN_W-1:0]       m_bin_re;
    logic signed [BIN_W-1:0]       m_bin_im;
    logic [BIN_INDEX_W-1:0]        m_bin_index;
    logic                          m_last_bin;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [CFG_INDEX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_wdata;
    int                            fail_count;
    int                            pending;
    logic                          quiet;
    logic                          hold_req;
    int                            cycles;

    windowed_direct_dft_magnitude_top #(.POINTS(POINTS)) dut (.*);

    wddm_checker #(.POINTS(POINTS)) u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("FAIL windowed_direct_dft_magnitude_top");
                $finish;
            end
        end
    end

    // result side: random stall bursts, one long stall on request
    initial begin
        int n;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req && m_valid) begin
                m_ready <= 1'b0;
                hold_req = 1'b0;
                repeat (3000) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 5);
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic idle_gap();
        int n;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 5);
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic send_sample(input logic [15:0] re, input logic [15:0] im);
        idle_gap();
        s_valid     <= 1'b1;
        s_sample_re <= re;
        s_sample_im <= im;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic bit0);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= {$urandom} & ~32'd1 | 32'(bit0);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain_bins();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_frame();
        for (int i = 0; i < POINTS; i++) send_sample(pick_sample(), pick_sample());
    endtask

    initial begin
        logic [15:0] edge_vals[5];
        edge_vals = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_sample_re = '0;
        s_sample_im = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        quiet       = 1'b0;
        hold_req    = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // unknown register index must be ignored
        write_reg(REG_UNMAPPED, 1'b1);
        write_reg(REG_WINDOW_ENABLE, 1'b0);
        write_reg(REG_MAGNITUDE_ENABLE, 1'b1);
        for (int i = 0; i < POINTS; i++)
            send_sample(edge_vals[i % 5], edge_vals[(i / 5) % 5]);
        drain_bins();

        write_reg(REG_WINDOW_ENABLE, 1'b1);
        write_reg(REG_MAGNITUDE_ENABLE, 1'b0);
        hold_req = 1'b1;
        random_frame();
        quiet = 1'b1;
        random_frame();
        drain_bins();

        if (fail_count == 0) begin
            $display("PASS windowed_direct_dft_magnitude_top");
        end else begin
            $display("FAIL windowed_direct_dft_magnitude_top");
        end
        $finish;
    end

endmodule
